@@ sv/cmh_pkg.sv @@
// ---------------------------------------------------------------------------
// cmh_pkg
// shared types and constants of the counting multiset histogram
// ---------------------------------------------------------------------------
package cmh_pkg;

  localparam int KIND_W  = 3;
  localparam int VALUE_W = 8;
  localparam int COUNT_W = 16;
  localparam int FREQ_W  = 16;
  localparam int TOTAL_W = 22;
  localparam int STAT_W  = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD        = 3'd0,
    KIND_REMOVE     = 3'd1,
    KIND_REMOVE_ALL = 3'd2,
    KIND_CLEAR      = 3'd3,
    KIND_LIST       = 3'd4
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_ABSENT = 2'd1,
    ST_RANGE  = 2'd2,
    ST_SAT    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_UPDATE,
    S_LIST_SCAN,
    S_LIST_EMIT
  } state_t;

  typedef struct packed {
    logic latch;
    logic upd;
    logic emit_simple;
    logic list_init;
    logic list_dec;
    logic list_emit;
    logic list_sel;
  } cmd_t;

  typedef struct packed {
    logic is_rmw;
    logic is_list;
    logic list_empty;
    logic nz_here;
    logic last_here;
    logic out_free;
  } stat_t;

endpackage

@@ sv/cmh_ram.sv @@
// ---------------------------------------------------------------------------
// cmh_ram
// generic single-port ram with registered read
// ---------------------------------------------------------------------------
module cmh_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ sv/cmh_ctrl.sv @@
// ---------------------------------------------------------------------------
// cmh_ctrl
// sequencer for read-modify-write, single results and the bin list walk
// ---------------------------------------------------------------------------
module cmh_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  cmh_pkg::stat_t stat,
  output cmh_pkg::cmd_t  cmd
);
  import cmh_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (stat.is_rmw) begin
          state_next = S_UPDATE;
        end else if (stat.is_list && !stat.list_empty) begin
          state_next = S_LIST_SCAN;
        end else if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      S_UPDATE: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      S_LIST_SCAN: begin
        if (stat.nz_here) state_next = S_LIST_EMIT;
      end
      S_LIST_EMIT: begin
        if (stat.out_free) state_next = stat.last_here ? S_IDLE : S_LIST_SCAN;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall  = 1'b0;
        cmd.latch = in_valid;
      end
      S_DISPATCH: begin
        if (!stat.is_rmw) begin
          if (stat.is_list && !stat.list_empty) begin
            cmd.list_init = 1'b1;
          end else begin
            cmd.emit_simple = stat.out_free;
          end
        end
      end
      S_UPDATE: begin
        cmd.upd = stat.out_free;
      end
      S_LIST_SCAN: begin
        cmd.list_sel = 1'b1;
        cmd.list_dec = !stat.nz_here;
      end
      S_LIST_EMIT: begin
        cmd.list_sel  = 1'b1;
        cmd.list_emit = stat.out_free;
        cmd.list_dec  = stat.out_free && !stat.last_here;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

@@ sv/cmh_dp.sv @@
// ---------------------------------------------------------------------------
// cmh_dp
// bin store, nonzero mask, running total, list index and result register
// ---------------------------------------------------------------------------
module cmh_dp #(
  parameter int NUM_BINS = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cmh_pkg::cmd_t                cmd,
  output cmh_pkg::stat_t               stat,
  input  logic [cmh_pkg::KIND_W-1:0]   kind,
  input  logic [cmh_pkg::VALUE_W-1:0]  value,
  input  logic [cmh_pkg::COUNT_W-1:0]  count,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [cmh_pkg::VALUE_W-1:0]  value_out,
  output logic [cmh_pkg::FREQ_W-1:0]   frequency,
  output logic [cmh_pkg::TOTAL_W-1:0]  total,
  output logic [cmh_pkg::STAT_W-1:0]   status,
  output logic                         last,
  output logic                         empty_res
);
  import cmh_pkg::*;

  localparam int IDX_W = $clog2(NUM_BINS);

  logic [KIND_W-1:0]   kind_r;
  logic [VALUE_W-1:0]  value_r;
  logic [COUNT_W-1:0]  count_r;
  logic [IDX_W-1:0]    idx;
  logic [NUM_BINS-1:0] nz;
  logic [TOTAL_W-1:0]  total_count;

  logic [IDX_W-1:0]    vi, addr;
  logic [FREQ_W-1:0]   rdata, b, nb, take;
  logic [FREQ_W:0]     sum;
  logic [TOTAL_W-1:0]  total_new;
  logic [STAT_W-1:0]   upd_status;
  logic [NUM_BINS-1:0] below;
  logic                in_range, is_bin_op, out_free;

  logic [VALUE_W-1:0]  simp_value;
  logic [TOTAL_W-1:0]  simp_total;
  logic [STAT_W-1:0]   simp_status;
  logic                simp_empty;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind_r  <= kind;
      value_r <= value;
      count_r <= count;
    end
  end

  assign vi   = value_r[IDX_W-1:0];
  assign addr = cmd.list_sel ? idx : vi;

  cmh_ram #(
    .WIDTH (FREQ_W),
    .DEPTH (NUM_BINS)
  ) u_bins (
    .clk   (clk),
    .we    (cmd.upd),
    .addr  (addr),
    .wdata (nb),
    .rdata (rdata)
  );

  // entries with a clear mask bit read as zero
  assign b = nz[vi] ? rdata : '0;

  always_comb begin
    sum        = {1'b0, b} + {1'b0, count_r};
    take       = b;
    nb         = b;
    upd_status = ST_OK;
    if (kind_r == KIND_ADD) begin
      nb = sum[FREQ_W] ? {FREQ_W{1'b1}} : sum[FREQ_W-1:0];
      if (sum[FREQ_W]) upd_status = ST_SAT;
    end else if (b == '0) begin
      upd_status = ST_ABSENT;
    end else begin
      if (kind_r == KIND_REMOVE && count_r < b) take = count_r;
      nb = b - take;
    end
  end

  assign total_new = total_count + TOTAL_W'(nb) - TOTAL_W'(b);

  assign in_range  = value_r < VALUE_W'(NUM_BINS);
  assign is_bin_op = kind_r == KIND_ADD || kind_r == KIND_REMOVE
                     || kind_r == KIND_REMOVE_ALL;

  always_comb begin
    for (int i = 0; i < NUM_BINS; i++) begin
      below[i] = IDX_W'(i) < idx;
    end
  end

  assign out_free = !out_valid || !out_stall;

  assign stat.is_rmw     = is_bin_op && in_range;
  assign stat.is_list    = kind_r == KIND_LIST;
  assign stat.list_empty = nz == '0;
  assign stat.nz_here    = nz[idx];
  assign stat.last_here  = (nz & below) == '0;
  assign stat.out_free   = out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      nz          <= '0;
      total_count <= '0;
      idx         <= '0;
    end else begin
      if (cmd.upd) begin
        nz[vi]      <= nb != '0;
        total_count <= total_new;
      end else if (cmd.emit_simple && kind_r == KIND_CLEAR) begin
        nz          <= '0;
        total_count <= '0;
      end
      if (cmd.list_init) begin
        idx <= IDX_W'(NUM_BINS - 1);
      end else if (cmd.list_dec) begin
        idx <= idx - IDX_W'(1);
      end
    end
  end

  always_comb begin
    simp_value  = '0;
    simp_total  = total_count;
    simp_status = ST_OK;
    simp_empty  = 1'b0;
    if (is_bin_op) begin
      simp_value  = value_r;
      simp_status = ST_RANGE;
    end else if (kind_r == KIND_CLEAR) begin
      simp_total = '0;
    end else if (kind_r == KIND_LIST) begin
      simp_empty = 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.upd || cmd.emit_simple || cmd.list_emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      value_out <= value_r;
      frequency <= nb;
      total     <= total_new;
      status    <= upd_status;
      last      <= 1'b1;
      empty_res <= 1'b0;
    end else if (cmd.emit_simple) begin
      value_out <= simp_value;
      frequency <= '0;
      total     <= simp_total;
      status    <= simp_status;
      last      <= 1'b1;
      empty_res <= simp_empty;
    end else if (cmd.list_emit) begin
      value_out <= {{(VALUE_W - IDX_W){1'b0}}, idx};
      frequency <= rdata;
      total     <= total_count;
      status    <= ST_OK;
      last      <= stat.last_here;
      empty_res <= 1'b0;
    end
  end

endmodule

@@ sv/counting_multiset_histogram.sv @@
// add, remove and remove all: bin read in dispatch and written back in update, no new item
// taken before the write, set by the read then write of the single bin ram port
// clear, out-of-range, unknown kinds and an empty list: result loaded in dispatch
// list: one bin examined per cycle from NUM_BINS-1 down, pausing to emit each nonzero bin
// reset clears the nonzero mask and total, no sweep of the bin ram
// ---------------------------------------------------------------------------
// counting_multiset_histogram
// multiset of small integers kept as per-value counts with a running total
// ---------------------------------------------------------------------------
module counting_multiset_histogram #(
  parameter int NUM_BINS = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [cmh_pkg::KIND_W-1:0]   kind,
  input  logic [cmh_pkg::VALUE_W-1:0]  value,
  input  logic [cmh_pkg::COUNT_W-1:0]  count,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [cmh_pkg::VALUE_W-1:0]  value_out,
  output logic [cmh_pkg::FREQ_W-1:0]   frequency,
  output logic [cmh_pkg::TOTAL_W-1:0]  total,
  output logic [cmh_pkg::STAT_W-1:0]   status,
  output logic                         last,
  output logic                         empty_res
);
  import cmh_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  cmh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  cmh_dp #(
    .NUM_BINS (NUM_BINS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .kind      (kind),
    .value     (value),
    .count     (count),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value_out (value_out),
    .frequency (frequency),
    .total     (total),
    .status    (status),
    .last      (last),
    .empty_res (empty_res)
  );

endmodule

@@ sv/cmh_checker.sv @@
// ---------------------------------------------------------------------------
// cmh_checker
// port-level checks of the counting multiset histogram
// ---------------------------------------------------------------------------
module cmh_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [cmh_pkg::VALUE_W-1:0]  value_out,
  input logic [cmh_pkg::FREQ_W-1:0]   frequency,
  input logic [cmh_pkg::STAT_W-1:0]   status,
  input logic                         last,
  input logic                         empty_res
);
  import cmh_pkg::*;

  a_stalled_beat_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(value_out) && $stable(frequency)
      && $stable(status) && $stable(last))
    else $error("stalled result beat changed");

  a_range_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_RANGE |-> frequency == '0 && last && !empty_res)
    else $error("out-of-range result malformed");

  a_absent_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_ABSENT |-> frequency == '0 && last)
    else $error("absent result malformed");

  a_empty_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && empty_res |-> last && value_out == '0 && frequency == '0
      && status == ST_OK)
    else $error("empty list result malformed");

endmodule

bind counting_multiset_histogram cmh_checker u_cmh_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .value_out (value_out),
  .frequency (frequency),
  .status    (status),
  .last      (last),
  .empty_res (empty_res)
);
